// ----- hw/rtl/kea_pkg.sv -----
package kea_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VTX_W = 6;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int SCAN_W = $clog2(MAX_VERTICES + 1);
	localparam int CFG_W = 7;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0] VC_RESET = CFG_W'(MAX_VERTICES);
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_CMP,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic cap;
		logic rd_a;
		logic rd_b;
		logic cap_la;
		logic merge;
		logic scan;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic differ;
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/kruskal_edge_acceptor.sv -----
// Kruskal spanning-tree edge acceptor. Feed edges already sorted by weight,
// one request per edge (s_tlast marks the final edge of a graph); each edge
// returns exactly one result. Component labels live in a single-port-read label
// memory, so an out-of-range edge skips the second lookup and the compare, an
// edge whose ends already share a component is rejected after the compare, and
// an accepted edge starts a merge that walks every label entry through the one
// read port, one entry per cycle. Results wait in an output register,
// so a new edge is taken while the previous result is still pending. After a
// last edge the labels and tree count return to their initial values at once.
// vertex_count may only be written while no edge is in flight.
module kruskal_edge_acceptor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// from_vertex[5:0], to_vertex[11:6], zero pad [15:12]
	input  logic [kea_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// accepted[0], tree_from[6:1], tree_to[12:7], tree_edge_count[18:13],
	// spanning_done[19], bad_vertex[20], zero pad [23:21]
	output logic [kea_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [kea_pkg::CFG_W-1:0]    cfg_wdata
);

	kea_pkg::cmd_t cmd;
	kea_pkg::sts_t sts;

	kea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kea_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hw/rtl/kea_ctrl.sv -----
module kea_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  kea_pkg::sts_t sts,
	output kea_pkg::cmd_t cmd
);

	kea_pkg::state_t state_q;
	kea_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kea_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			kea_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = kea_pkg::ST_RD_A;
				end
			end
			kea_pkg::ST_RD_A: begin
				cmd.rd_a = 1'b1;
				// skip the second lookup and the compare for an out-of-range endpoint
				state_d = sts.bad ? kea_pkg::ST_DONE : kea_pkg::ST_RD_B;
			end
			kea_pkg::ST_RD_B: begin
				cmd.rd_b = 1'b1;
				cmd.cap_la = 1'b1;
				state_d = kea_pkg::ST_CMP;
			end
			kea_pkg::ST_CMP: begin
				if (sts.differ) begin
					cmd.merge = 1'b1;
					state_d = kea_pkg::ST_SCAN;
				end else begin
					state_d = kea_pkg::ST_DONE;
				end
			end
			kea_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = kea_pkg::ST_DONE;
				end
			end
			kea_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = kea_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kea_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/kea_dp.sv -----
module kea_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [kea_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [kea_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                           cfg_we,
	input  logic [kea_pkg::CFG_W-1:0]      cfg_wdata,
	input  kea_pkg::cmd_t                  cmd,
	output kea_pkg::sts_t                  sts
);

	localparam logic [kea_pkg::CFG_W-1:0] VC_MAX = kea_pkg::CFG_W'(kea_pkg::MAX_VERTICES);

	logic [kea_pkg::CFG_W-1:0]  vc_q;
	logic [kea_pkg::CFG_W-1:0]  eff_vc;
	logic [kea_pkg::VTX_W-1:0]  a_q;
	logic [kea_pkg::VTX_W-1:0]  b_q;
	logic                       last_q;
	logic                       bad_q;
	logic                       acc_q;
	logic [kea_pkg::CNT_W-1:0]  cnt_q;
	logic [kea_pkg::VTX_W-1:0]  la_q;
	logic [kea_pkg::VTX_W-1:0]  lb_q;
	logic [kea_pkg::SCAN_W-1:0] scan_q;

	logic [kea_pkg::VTX_W-1:0]  lbl_mem [kea_pkg::MAX_VERTICES];
	logic [kea_pkg::MAX_VERTICES-1:0] lbl_vld_q;
	logic [kea_pkg::ADDR_W-1:0] rd_addr;
	logic [kea_pkg::VTX_W-1:0]  rdata_q;

	logic                       scan_vld_s1;
	logic [kea_pkg::ADDR_W-1:0] scan_addr_s1;
	logic                       scan_wr;

	logic [kea_pkg::VTX_W-1:0]  in_from;
	logic [kea_pkg::VTX_W-1:0]  in_to;
	logic                       in_bad;
	logic [kea_pkg::CFG_W-1:0]  cnt_plus1;
	logic                       span_done;

	// clamp the configured count to the label store depth
	assign eff_vc = (vc_q > VC_MAX) ? VC_MAX : vc_q;

	assign in_from = s_tdata[kea_pkg::VTX_W-1:0];
	assign in_to   = s_tdata[2*kea_pkg::VTX_W-1:kea_pkg::VTX_W];
	assign in_bad  = ({1'b0, in_from} >= eff_vc) || ({1'b0, in_to} >= eff_vc);

	assign cnt_plus1 = {1'b0, cnt_q} + kea_pkg::CFG_W'(1);
	assign span_done = cnt_plus1 >= eff_vc;

	assign sts.bad      = bad_q;
	assign sts.differ   = rdata_q != la_q;
	assign sts.scan_end = scan_q == kea_pkg::SCAN_W'(kea_pkg::MAX_VERTICES);
	assign sts.out_free = !m_tvalid || m_tready;

	always_comb begin
		if (cmd.rd_a) begin
			rd_addr = a_q[kea_pkg::ADDR_W-1:0];
		end else if (cmd.rd_b) begin
			rd_addr = b_q[kea_pkg::ADDR_W-1:0];
		end else begin
			rd_addr = scan_q[kea_pkg::ADDR_W-1:0];
		end
	end

	assign scan_wr = scan_vld_s1 && (rdata_q == lb_q);

	// label store: an entry never written since the last reinit reads as its own index
	always_ff @(posedge clk) begin
		if (scan_wr) begin
			lbl_mem[scan_addr_s1] <= la_q;
		end
		rdata_q <= lbl_vld_q[rd_addr] ? lbl_mem[rd_addr] : kea_pkg::VTX_W'(rd_addr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbl_vld_q <= '0;
		end else if (cmd.load_out && last_q) begin
			lbl_vld_q <= '0;
		end else if (scan_wr) begin
			lbl_vld_q[scan_addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= kea_pkg::VC_RESET;
		end else if (cfg_we) begin
			vc_q <= cfg_wdata;
		end
	end

	// request registers and per-edge working values
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			a_q    <= in_from;
			b_q    <= in_to;
			last_q <= s_tlast;
			bad_q  <= in_bad;
		end
		if (cmd.cap_la) begin
			la_q <= rdata_q;
		end
		if (cmd.merge) begin
			lb_q <= rdata_q;
		end
		scan_addr_s1 <= scan_q[kea_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 1'b0;
			cnt_q       <= '0;
			scan_q      <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan && !sts.scan_end;
			if (cmd.cap) begin
				acc_q <= 1'b0;
			end
			if (cmd.merge) begin
				acc_q  <= 1'b1;
				scan_q <= '0;
				if (cnt_q != kea_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + kea_pkg::CNT_W'(1);
				end
			end else if (cmd.scan) begin
				scan_q <= scan_q + kea_pkg::SCAN_W'(1);
			end
			if (cmd.load_out && last_q) begin
				cnt_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata <= {3'b000, bad_q, span_done, cnt_q,
				acc_q ? b_q : kea_pkg::VTX_W'(0),
				acc_q ? a_q : kea_pkg::VTX_W'(0),
				acc_q};
		end
	end

	a_acc_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[20]))
		else $error("edge both accepted and flagged bad");

	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[18:13] != '0)
		else $error("accepted edge reported with zero tree count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && last_q |=> cnt_q == '0 && lbl_vld_q == '0)
		else $error("labels or count not reinitialized after last edge");

	a_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		scan_wr |-> $past(cmd.scan) && acc_q && !bad_q)
		else $error("label write outside a merge scan");

endmodule
